>>> sv/qte_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qte_pkg
// Shared widths, types and the CORDIC angle table for the quaternion to
// Euler angle converter.
// ---------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int ANG_TABLE_LEN = 24;
    // iterations actually built
    localparam int NUM_ITER = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN :
                              ((CORDIC_STEPS < 0) ? 0 : CORDIC_STEPS);

    // restoring square root of a 57-bit radicand: 29 result bits
    localparam int SQ_STAGES = 29;
    localparam int SQ_W      = 58;

    localparam int SUM_W = 34;   // Q.28 sums of products
    localparam int CW    = 37;   // CORDIC vector width, headroom for gain
    localparam int AW    = 26;   // angle accumulator, 2^-16 degree

    localparam int DEG90_FINE = 5898240;
    localparam int ONE_Q28    = 268435456;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [CW-1:0]    cvec_t;
    typedef logic signed [AW-1:0]    ang_t;

    function automatic ang_t atan_fine(input int idx);
        ang_t r;
        case (idx)
            0:       r = 26'sd2949120;
            1:       r = 26'sd1740967;
            2:       r = 26'sd919879;
            3:       r = 26'sd466945;
            4:       r = 26'sd234379;
            5:       r = 26'sd117304;
            6:       r = 26'sd58666;
            7:       r = 26'sd29335;
            8:       r = 26'sd14668;
            9:       r = 26'sd7334;
            10:      r = 26'sd3667;
            11:      r = 26'sd1833;
            12:      r = 26'sd917;
            13:      r = 26'sd458;
            14:      r = 26'sd229;
            15:      r = 26'sd115;
            16:      r = 26'sd57;
            17:      r = 26'sd29;
            18:      r = 26'sd14;
            19:      r = 26'sd7;
            20:      r = 26'sd4;
            21:      r = 26'sd2;
            22:      r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/qte_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qte_in_if
// Quaternion input channel: valid/ready plus four Q2.14 components.
// ---------------------------------------------------------------------------
interface qte_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

>>> sv/qte_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qte_out_if
// Euler angle output channel: valid/ready plus three angles and clamp flag.
// ---------------------------------------------------------------------------
interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_x;
    logic signed [14:0] angle_y;
    logic signed [15:0] angle_z;
    logic               pitch_clamped;

    modport source (output valid, angle_x, angle_y, angle_z, pitch_clamped,
                    input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, pitch_clamped,
                    output ready);
endinterface
`default_nettype wire

>>> sv/qte_cordic.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in 2^-16 degree, one stage per
// iteration after a quadrant pre-rotation stage.
// ---------------------------------------------------------------------------
module qte_cordic
    import qte_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire cvec_t y_in,
    input  wire cvec_t x_in,
    output ang_t       z_out
);

    cvec_t x_reg [0:NUM_ITER];
    cvec_t y_reg [0:NUM_ITER];
    ang_t  z_reg [0:NUM_ITER];

    // fold left half-plane onto the right
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    z_reg[0] <= AW'(DEG90_FINE);
                end
                else
                begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    z_reg[0] <= -AW'(DEG90_FINE);
                end
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NUM_ITER; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_fine(i);
                end
                else if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_fine(i);
                end
                else
                begin
                    // on the axis: no further rotation
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end
            end
        end
    end

    assign z_out = z_reg[NUM_ITER];

endmodule
`default_nettype wire

>>> sv/quaternion_to_euler_degrees_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// quaternion_to_euler_degrees_top
// Pipeline from accepted quaternion word to result word: 3 product/sum
//   stages, 29 square-root stages, 1 + NUM_ITER CORDIC stages and
//   1 output register.
// Throughput: one word per cycle; the whole pipeline advances together and
//   halts only while the output register holds a word not yet taken.
// Reset: rst_n (async, active low) clears all valid bits; data regs unreset.
// ---------------------------------------------------------------------------
module quaternion_to_euler_degrees_top
    import qte_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    qte_in_if.sink   quat,
    qte_out_if.source euler
);

    localparam int LIM_XZ = 23040;
    localparam int LIM_Y  = 11520;

    // global advance: pipeline moves when the output slot is free or drains
    logic en;
    logic out_vld_reg;
    assign en         = !out_vld_reg || euler.ready;
    assign quat.ready = en;

    // ---------------- stage 1: the nine products ----------------
    logic              v1_reg;
    logic signed [31:0] wx_reg, yz_reg, wz_reg, xy_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] wy_reg, zx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= quat.quat_w * quat.quat_x;
            yz_reg <= quat.quat_y * quat.quat_z;
            wz_reg <= quat.quat_w * quat.quat_z;
            xy_reg <= quat.quat_x * quat.quat_y;
            xx_reg <= quat.quat_x * quat.quat_x;
            yy_reg <= quat.quat_y * quat.quat_y;
            zz_reg <= quat.quat_z * quat.quat_z;
            wy_reg <= quat.quat_w * quat.quat_y;
            zx_reg <= quat.quat_z * quat.quat_x;
        end
    end

    // ---------------- stage 2: Q.28 sums ----------------
    logic v2_reg;
    sum_t sx_reg, cx_reg, sz_reg, cz_reg, s_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
            sz_reg <= (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
            s_reg  <= (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
            cx_reg <= SUM_W'(ONE_Q28) - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
            cz_reg <= SUM_W'(ONE_Q28) - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
        end
    end

    // ---------------- stage 3: pitch clamp test and 1 - s^2 ----------------
    logic        clamp_c;
    logic [27:0] ss_c;
    logic [55:0] ss_sq_c;
    sum_t        s_abs_c;
    assign clamp_c = (s_reg >= SUM_W'(ONE_Q28)) || (s_reg <= -SUM_W'(ONE_Q28));
    assign s_abs_c = (s_reg < 0) ? -s_reg : s_reg;
    assign ss_c    = clamp_c ? 28'd0 : s_abs_c[27:0];
    // full 56-bit square, 28 x 28 bits
    assign ss_sq_c = 56'(ss_c) * 56'(ss_c);

    // sqrt pipeline; index 0 is the stage 3 register
    logic            vs_reg  [0:SQ_STAGES];
    logic            cl_reg  [0:SQ_STAGES];
    sum_t            psx_reg [0:SQ_STAGES];
    sum_t            pcx_reg [0:SQ_STAGES];
    sum_t            psz_reg [0:SQ_STAGES];
    sum_t            pcz_reg [0:SQ_STAGES];
    sum_t            ps_reg  [0:SQ_STAGES];
    logic [SQ_W-1:0] rad_reg [0:SQ_STAGES];
    logic [SQ_W-1:0] root_reg[0:SQ_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_reg[0]   <= clamp_c;
            psx_reg[0]  <= sx_reg;
            pcx_reg[0]  <= cx_reg;
            psz_reg[0]  <= sz_reg;
            pcz_reg[0]  <= cz_reg;
            ps_reg[0]   <= s_reg;
            rad_reg[0]  <= (SQ_W'(1) << 56) - SQ_W'(ss_sq_c);
            root_reg[0] <= '0;
        end
    end

    // one result bit per stage, test bit 4^(28-k)
    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (56 - 2 * k);
        logic [SQ_W-1:0] trial;
        assign trial = root_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cl_reg[k+1]  <= cl_reg[k];
                psx_reg[k+1] <= psx_reg[k];
                pcx_reg[k+1] <= pcx_reg[k];
                psz_reg[k+1] <= psz_reg[k];
                pcz_reg[k+1] <= pcz_reg[k];
                ps_reg[k+1]  <= ps_reg[k];
                if (rad_reg[k] >= trial)
                begin
                    rad_reg[k+1]  <= rad_reg[k] - trial;
                    root_reg[k+1] <= (root_reg[k] >> 1) + BIT;
                end
                else
                begin
                    rad_reg[k+1]  <= rad_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
            end
        end
    end

    // ---------------- CORDIC stages ----------------
    cvec_t ys_in, xs_in;
    ang_t  zx_fine, zz_fine, zy_fine;

    assign ys_in = cl_reg[SQ_STAGES] ? '0 : CW'(ps_reg[SQ_STAGES]);
    assign xs_in = cl_reg[SQ_STAGES] ? '0 : CW'(root_reg[SQ_STAGES][28:0]);

    qte_cordic u_cordic_x (
        .clk   (clk),
        .en    (en),
        .y_in  (CW'(psx_reg[SQ_STAGES])),
        .x_in  (CW'(pcx_reg[SQ_STAGES])),
        .z_out (zx_fine)
    );

    qte_cordic u_cordic_y (
        .clk   (clk),
        .en    (en),
        .y_in  (ys_in),
        .x_in  (xs_in),
        .z_out (zy_fine)
    );

    qte_cordic u_cordic_z (
        .clk   (clk),
        .en    (en),
        .y_in  (CW'(psz_reg[SQ_STAGES])),
        .x_in  (CW'(pcz_reg[SQ_STAGES])),
        .z_out (zz_fine)
    );

    // side band alongside the CORDIC: valid, clamp flag, pitch sign
    logic vc_reg  [0:NUM_ITER];
    logic ccl_reg [0:NUM_ITER];
    logic cpos_reg[0:NUM_ITER];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ccl_reg[0]  <= cl_reg[SQ_STAGES];
            cpos_reg[0] <= ps_reg[SQ_STAGES] > 0;
        end
    end

    for (genvar j = 0; j < NUM_ITER; j++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ccl_reg[j+1]  <= ccl_reg[j];
                cpos_reg[j+1] <= cpos_reg[j];
            end
        end
    end

    // ---------------- valid chain, the only reset state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k <= SQ_STAGES; k++)
            begin
                vs_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= NUM_ITER; j++)
            begin
                vc_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= quat.valid;
            v2_reg    <= v1_reg;
            vs_reg[0] <= v2_reg;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                vs_reg[k+1] <= vs_reg[k];
            end
            vc_reg[0] <= vs_reg[SQ_STAGES];
            for (int j = 0; j < NUM_ITER; j++)
            begin
                vc_reg[j+1] <= vc_reg[j];
            end
        end
    end

    // ---------------- rounding to 1/128 degree and clamp ----------------
    function automatic logic signed [17:0] to_units(input ang_t fine, input int lim);
        logic signed [AW:0]  t;
        logic signed [17:0]  a;
        t = (AW+1)'(fine) + (AW+1)'(256);
        a = 18'(t >>> 9);
        if (a > 18'(lim))
        begin
            a = 18'(lim);
        end
        if (a < -18'(lim))
        begin
            a = -18'(lim);
        end
        return a;
    endfunction

    logic signed [17:0] ax_c, ay_c, az_c;
    assign ax_c = to_units(zx_fine, LIM_XZ);
    assign az_c = to_units(zz_fine, LIM_XZ);
    assign ay_c = ccl_reg[NUM_ITER] ? (cpos_reg[NUM_ITER] ? 18'(LIM_Y) : -18'(LIM_Y))
                                    : to_units(zy_fine, LIM_Y);

    logic signed [15:0] ax_reg, az_reg;
    logic signed [14:0] ay_reg;
    logic               flag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= ax_c[15:0];
            ay_reg   <= ay_c[14:0];
            az_reg   <= az_c[15:0];
            flag_reg <= ccl_reg[NUM_ITER];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vc_reg[NUM_ITER];
        end
    end

    assign euler.valid         = out_vld_reg;
    assign euler.angle_x       = ax_reg;
    assign euler.angle_y       = ay_reg;
    assign euler.angle_z       = az_reg;
    assign euler.pitch_clamped = flag_reg;

`ifndef SYNTHESIS
    // a clamped pitch always lands exactly on a pole
    a_clamp_pole: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid && euler.pitch_clamped |->
            (euler.angle_y == 15'sd11520 || euler.angle_y == -15'sd11520))
        else $error("clamped pitch not at +-90 degrees");

    // roll stays inside +-180 degrees
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.angle_x <= 16'sd23040 && euler.angle_x >= -16'sd23040))
        else $error("roll out of range");

    // a held output word freezes the whole pipeline
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid && !euler.ready |=> euler.valid && $stable(vc_reg[NUM_ITER]))
        else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

>>> test/quaternion_to_euler_degrees_checker.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler_degrees_checker
// Watches both channels, computes the expected Euler angles for every
// accepted quaternion word and compares each result word in order.
// ---------------------------------------------------------------------------
module quaternion_to_euler_degrees_checker
    import qte_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    qte_in_if.sink   quat,
    qte_out_if.sink  euler,
    output int       fail_count,
    output int       pending,
    output int       seen_clamped,
    output int       seen_words
);

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [14:0] ay;
        logic signed [15:0] az;
        logic               clamp;
    } euler_t;

    euler_t angles_due[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring CORDIC, angle in 2^-16 degree
    function automatic longint vector_angle(longint y, longint x);
        longint z, t, nx, ny;
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0};
        int n;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = DEG90_FINE;
            end
            else
            begin
                x = -y; y = t; z = -DEG90_FINE;
            end
        end
        n = (CORDIC_STEPS > 24) ? 24 : ((CORDIC_STEPS < 0) ? 0 : CORDIC_STEPS);
        for (int i = 0; i < n; i++)
        begin
            if (y == 0)
                break;
            if (y > 0)
            begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                z += tbl[i];
            end
            else
            begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                z -= tbl[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint to_units(longint fine, longint lim);
        longint a;
        a = floor_shr(fine + 256, 9);
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        return a;
    endfunction

    function automatic euler_t predict_angles(longint x, longint y, longint z,
                                              longint w);
        euler_t e;
        longint sx, cx, sz, cz, s, ss, c;
        sx = 2 * (w * x + y * z);
        cx = ONE_Q28 - 2 * (x * x + y * y);
        sz = 2 * (w * z + x * y);
        cz = ONE_Q28 - 2 * (y * y + z * z);
        s  = 2 * (w * y - z * x);
        e.ax = 16'(to_units(vector_angle(sx, cx), 23040));
        e.az = 16'(to_units(vector_angle(sz, cz), 23040));
        if (s >= ONE_Q28 || s <= -ONE_Q28)
        begin
            e.ay = (s > 0) ? 15'sd11520 : -15'sd11520;
            e.clamp = 1'b1;
        end
        else
        begin
            ss = (s < 0) ? -s : s;
            c = root_floor((64'd1 << 56) - longint'(ss * ss));
            e.ay = 15'(to_units(vector_angle(s, c), 11520));
            e.clamp = 1'b0;
        end
        return e;
    endfunction

    assign pending = angles_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        euler_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            seen_clamped <= 0;
            seen_words <= 0;
        end
        else
        begin
            if (quat.valid && quat.ready)
                angles_due.push_back(predict_angles(quat.quat_x, quat.quat_y,
                                                    quat.quat_z, quat.quat_w));
            if (euler.valid && euler.ready)
            begin
                seen_words <= seen_words + 1;
                if (euler.pitch_clamped)
                    seen_clamped <= seen_clamped + 1;
                if (angles_due.size() == 0)
                begin
                    $display("%0t: unexpected word x=%0d y=%0d z=%0d c=%0b", $time,
                             euler.angle_x, euler.angle_y, euler.angle_z,
                             euler.pitch_clamped);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = angles_due.pop_front();
                    if (want.ax !== euler.angle_x || want.ay !== euler.angle_y ||
                        want.az !== euler.angle_z || want.clamp !== euler.pitch_clamped)
                    begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d c=%0b", $time,
                                 want.ax, want.ay, want.az, want.clamp);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d c=%0b", $time,
                                 euler.angle_x, euler.angle_y, euler.angle_z,
                                 euler.pitch_clamped);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> test/quaternion_to_euler_degrees_top_tb.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler_degrees_top_tb
// Drives quaternion words (corners, gimbal-lock poses, unit quaternions and
// raw bit patterns) with random gaps and output stalls; a checker predicts
// and compares every Euler angle word.
// ---------------------------------------------------------------------------
module quaternion_to_euler_degrees_top_tb;
    import qte_pkg::*;

    localparam int RANDOM_WORDS = 1330;
    localparam int LATENCY      = 34 + NUM_ITER;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    int   cycles;
    int   fail_count, pending, seen_clamped, seen_words;
    int   sent;
    bit   hold_long;   // receiver parks ready low for the back-pressure test

    qte_in_if  quat ();
    qte_out_if euler ();

    quaternion_to_euler_degrees_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat.sink),
        .euler (euler.source)
    );

    quaternion_to_euler_degrees_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .quat         (quat.sink),
        .euler        (euler.sink),
        .fail_count   (fail_count),
        .pending      (pending),
        .seen_clamped (seen_clamped),
        .seen_words   (seen_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("quaternion_to_euler_degrees_top_tb: done, errors");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // send one word, holding it until the handshake completes
    task automatic send_word(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [15:0] w);
        int gap;
        gap = (sent < 2000 && ($urandom_range(0, 3) == 0)) ? 0 : pick_gap();
        if (sent % 300 < 60)
            gap = 0;   // stretches with no idling
        repeat (gap)
        begin
            quat.valid <= 1'b0;
            @(negedge clk);
        end
        quat.valid  <= 1'b1;
        quat.quat_x <= x;
        quat.quat_y <= y;
        quat.quat_z <= z;
        quat.quat_w <= w;
        @(posedge clk);
        while (!quat.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // random component: mostly in range, sometimes any bit pattern
    function automatic logic [15:0] rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (r < 9)
            return 16'($urandom);
        return ($urandom_range(0, 1)) ? 16'sh4000 : 16'shC000;
    endfunction

    // receiver: random stalls; long hold-offs while the sender keeps going
    initial
    begin
        int gap;
        euler.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                euler.ready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_long = 1'b0;
            end
            gap = pick_gap();
            if (gap == 0 || cycles % 1000 < 150)
                euler.ready <= 1'b1;
            else
            begin
                euler.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [15:0] px, py, pz, pw;
        int ang;
        quat.valid  = 1'b0;
        quat.quat_x = '0;
        quat.quat_y = '0;
        quat.quat_z = '0;
        quat.quat_w = '0;
        rst_n = 1'b0;
        sent = 0;
        hold_long = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: identity, axis rotations, both atan2 operands zero,
        // negative x axis, gimbal lock both ways, raw corners
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_word(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_word(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_word(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);        // +90 roll
        send_word(16'sd0, 16'sd11586, 16'sd0, 16'sd11586);        // pitch at +1
        send_word(16'sd0, -16'sd11586, 16'sd0, 16'sd11586);       // pitch at -1
        send_word(16'sd11586, 16'sd0, 16'sd11586, 16'sd0);        // -zx clamp
        send_word(16'sd0, 16'sd11584, 16'sd0, 16'sd11584);        // just under one
        send_word(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        send_word(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_word(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_word(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(16'sd1, 16'sd0, 16'sd0, -16'sd1);
        send_word(16'sd0, 16'sd0, 16'sd1, 16'sd0);
        send_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);

        // back-pressure: hold the output long enough to fill the pipeline
        hold_long = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 600)
                hold_long = 1'b1;
            if ($urandom_range(0, 3) != 0)
            begin
                // random components; when ang is 0, x and z are scaled by 3/8
                ang = $urandom_range(0, 3);
                px = rand_comp();
                py = rand_comp();
                pz = rand_comp();
                pw = 16'($signed($urandom_range(0, 32768)) - 16384);
                if (ang == 0)
                begin
                    px = 16'(($signed(px) * 3) / 8);
                    pz = 16'(($signed(pz) * 3) / 8);
                end
                send_word(px, py, pz, pw);
            end
            else
                send_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        quat.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d quaternion words, %0d results, %0d with pitch clamped",
                 sent, seen_words, seen_clamped);
        $display("random stalls on both sides plus long output hold-offs");
        if (fail_count == 0 && pending == 0)
            $display("quaternion_to_euler_degrees_top_tb: done, clean");
        else
            $display("quaternion_to_euler_degrees_top_tb: done, errors");
        $finish;
    end

endmodule
